[rtl/sorted_timer_queue_unit_defines.svh]
// Assertion macros used by the checker file of the timer queue.
`ifndef SORTED_TIMER_QUEUE_UNIT_DEFINES_SVH
`define SORTED_TIMER_QUEUE_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, quiet while rst_n is low.
`define STQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, quiet while rst_n is low.
`define STQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/stq_pkg.sv]
`default_nettype none

package stq_pkg;

  localparam int REQ_W      = 2;
  localparam int DELAY_IN_W = 20;
  localparam int TAG_W      = 16;
  localparam int CID_W      = 16;
  localparam int STATUS_W   = 3;
  localparam int OUT_ID_W   = 16;
  localparam int SEC_W      = 32;

  typedef enum logic [REQ_W-1:0] {
    REQ_SCHED  = 2'd0,
    REQ_CANCEL = 2'd1,
    REQ_TICK   = 2'd2,
    REQ_NONE   = 2'd3
  } req_t;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK       = 3'd0,
    STS_ZERO     = 3'd1,
    STS_FULL     = 3'd2,
    STS_NOTFOUND = 3'd3,
    STS_TICK     = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_INSERT,
    S_PREFIX,
    S_REMOVE,
    S_RESP
  } state_t;

  typedef struct packed {
    logic    latch;
    logic    decode;
    logic    tick_adv;
    logic    insert;
    logic    prefix;
    logic    remove;
    logic    load_out;
    status_t status;
    logic    fired;
    logic    assign_id;
  } ctl_cmd_t;

  typedef struct packed {
    req_t req;
    logic delay_zero;
    logic full;
    logic any_match;
    logic head_due;
    logic prefix_last;
  } dp_stat_t;

endpackage

`default_nettype wire

[rtl/stq_ctrl.sv]
`default_nettype none

module stq_ctrl import stq_pkg::*; (
  input  wire           clk,
  input  wire           rst_n,
  input  wire           in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  wire           out_stall,
  input  wire dp_stat_t stat,
  output ctl_cmd_t      cmd
);

  state_t  state_r, state_nxt;
  status_t status_r, status_nxt;
  logic    fired_r, fired_nxt;
  logic    assign_r, assign_nxt;
  logic    out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      status_r    <= STS_OK;
      fired_r     <= 1'b0;
      assign_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      status_r    <= status_nxt;
      fired_r     <= fired_nxt;
      assign_r    <= assign_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    status_nxt    = status_r;
    fired_nxt     = fired_r;
    assign_nxt    = assign_r;
    cmd           = '0;
    cmd.status    = status_r;
    cmd.fired     = fired_r;
    cmd.assign_id = assign_r;
    in_stall      = (state_r != S_IDLE);
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.decode = 1'b1;
        fired_nxt  = 1'b0;
        assign_nxt = 1'b0;
        unique case (stat.req)
          REQ_SCHED: begin
            priority if (stat.delay_zero) begin
              status_nxt = STS_ZERO;
              state_nxt  = S_RESP;
            end else if (stat.full) begin
              status_nxt = STS_FULL;
              state_nxt  = S_RESP;
            end else begin
              status_nxt = STS_OK;
              assign_nxt = 1'b1;
              state_nxt  = S_INSERT;
            end
          end
          REQ_CANCEL: begin
            if (stat.any_match) begin
              status_nxt = STS_OK;
              state_nxt  = S_PREFIX;
            end else begin
              status_nxt = STS_NOTFOUND;
              state_nxt  = S_RESP;
            end
          end
          REQ_TICK: begin
            cmd.tick_adv = 1'b1;
            status_nxt   = STS_TICK;
            if (stat.head_due) begin
              fired_nxt = 1'b1;
              state_nxt = S_REMOVE;
            end else begin
              state_nxt = S_RESP;
            end
          end
          REQ_NONE: begin
            status_nxt = STS_OK;
            state_nxt  = S_RESP;
          end
          default: begin
            status_nxt = STS_OK;
            state_nxt  = S_RESP;
          end
        endcase
      end
      S_INSERT: begin
        cmd.insert = 1'b1;
        state_nxt  = S_RESP;
      end
      S_PREFIX: begin
        cmd.prefix = 1'b1;
        if (stat.prefix_last) begin
          state_nxt = S_REMOVE;
        end
      end
      S_REMOVE: begin
        cmd.remove = 1'b1;
        state_nxt  = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_r || !out_stall) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

[rtl/stq_dpath.sv]
`default_nettype none

module stq_dpath import stq_pkg::*; #(
  parameter int NUM_TIMERS = 16,
  parameter int ID_BITS    = 16,
  parameter int DELAY_BITS = 20
) (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire  [REQ_W-1:0]       in_req_type,
  input  wire  [DELAY_IN_W-1:0]  in_delay_seconds,
  input  wire  [TAG_W-1:0]       in_tag,
  input  wire  [CID_W-1:0]       in_cancel_id,
  input  wire  ctl_cmd_t         cmd,
  output dp_stat_t               stat,
  output logic [STATUS_W-1:0]    out_status,
  output logic [OUT_ID_W-1:0]    out_assigned_id,
  output logic                   out_fired,
  output logic [OUT_ID_W-1:0]    out_fired_id,
  output logic [TAG_W-1:0]       out_fired_tag
);

  localparam int CNT_W  = $clog2(NUM_TIMERS + 1);
  localparam int LOG_N  = $clog2(NUM_TIMERS);
  localparam int STEP_W = (LOG_N > 1) ? $clog2(LOG_N) : 1;
  localparam int DLY_W  = (DELAY_BITS < DELAY_IN_W) ? DELAY_BITS : DELAY_IN_W;

  req_t                  req_r;
  logic [DLY_W-1:0]      delay_r;
  logic [TAG_W-1:0]      tag_r;
  logic [CID_W-1:0]      cid_r;
  logic [SEC_W-1:0]      sec_r;
  logic [ID_BITS-1:0]    next_id_r;
  logic [ID_BITS-1:0]    nid_r;
  logic [SEC_W-1:0]      wake_r;
  logic [NUM_TIMERS-1:0] kill_r;
  logic [STEP_W-1:0]     step_r;
  logic [CNT_W-1:0]      count_r;
  logic [ID_BITS-1:0]    head_id_r;
  logic [TAG_W-1:0]      head_tag_r;

  logic [SEC_W-1:0]      exp_r  [NUM_TIMERS];
  logic [ID_BITS-1:0]    id_r   [NUM_TIMERS];
  logic [TAG_W-1:0]      etag_r [NUM_TIMERS];

  logic [SEC_W-1:0]      exp_lft  [NUM_TIMERS];
  logic [ID_BITS-1:0]    id_lft   [NUM_TIMERS];
  logic [TAG_W-1:0]      etag_lft [NUM_TIMERS];
  logic [SEC_W-1:0]      exp_rgt  [NUM_TIMERS];
  logic [ID_BITS-1:0]    id_rgt   [NUM_TIMERS];
  logic [TAG_W-1:0]      etag_rgt [NUM_TIMERS];

  logic [STATUS_W-1:0]   status_r;
  logic [OUT_ID_W-1:0]   aid_r;
  logic                  fired_r;
  logic [OUT_ID_W-1:0]   fid_r;
  logic [TAG_W-1:0]      ftag_r;

  logic [SEC_W-1:0]      delay_eff;
  logic [SEC_W-1:0]      sec_inc;
  logic [ID_BITS-1:0]    id_inc;
  logic [ID_BITS-1:0]    nid_calc;
  logic [NUM_TIMERS-1:0] match;
  logic [NUM_TIMERS:0]   ge_ext;
  logic [LOG_N:0]        shamt;
  logic [ID_BITS+OUT_ID_W-1:0] nid_ext;
  logic [ID_BITS+OUT_ID_W-1:0] head_ext;

  assign delay_eff = SEC_W'(delay_r);
  assign sec_inc   = sec_r + SEC_W'(1);
  assign id_inc    = next_id_r + ID_BITS'(1);
  assign nid_calc  = (id_inc == '0) ? ID_BITS'(1) : id_inc;
  assign shamt     = (LOG_N + 1)'(1) << step_r;
  assign nid_ext   = {{OUT_ID_W{1'b0}}, nid_r};
  assign head_ext  = {{OUT_ID_W{1'b0}}, head_id_r};
  assign ge_ext[0] = 1'b1;

  for (genvar i = 0; i < NUM_TIMERS; i++) begin : g_cmp
    assign match[i] = (CNT_W'(i) < count_r) &&
                      ({{CID_W{1'b0}}, id_r[i]} == {{ID_BITS{1'b0}}, cid_r});
    assign ge_ext[i+1] = (CNT_W'(i) < count_r) && (exp_r[i] <= wake_r);
    if (i == 0) begin : g_first
      assign exp_lft[i]  = exp_r[i];
      assign id_lft[i]   = id_r[i];
      assign etag_lft[i] = etag_r[i];
    end else begin : g_mid
      assign exp_lft[i]  = exp_r[i-1];
      assign id_lft[i]   = id_r[i-1];
      assign etag_lft[i] = etag_r[i-1];
    end
    if (i == NUM_TIMERS - 1) begin : g_last
      assign exp_rgt[i]  = exp_r[i];
      assign id_rgt[i]   = id_r[i];
      assign etag_rgt[i] = etag_r[i];
    end else begin : g_inner
      assign exp_rgt[i]  = exp_r[i+1];
      assign id_rgt[i]   = id_r[i+1];
      assign etag_rgt[i] = etag_r[i+1];
    end

    always_ff @(posedge clk) begin
      if (cmd.insert && !ge_ext[i+1]) begin
        if (ge_ext[i]) begin
          exp_r[i]  <= wake_r;
          id_r[i]   <= nid_r;
          etag_r[i] <= tag_r;
        end else begin
          exp_r[i]  <= exp_lft[i];
          id_r[i]   <= id_lft[i];
          etag_r[i] <= etag_lft[i];
        end
      end else if (cmd.remove && kill_r[i]) begin
        exp_r[i]  <= exp_rgt[i];
        id_r[i]   <= id_rgt[i];
        etag_r[i] <= etag_rgt[i];
      end
    end
  end

  always_comb begin
    stat             = '0;
    stat.req         = req_r;
    stat.delay_zero  = (delay_r == '0);
    stat.full        = (count_r == CNT_W'(NUM_TIMERS));
    stat.any_match   = |match;
    stat.head_due    = (count_r != '0) && (exp_r[0] <= sec_inc);
    stat.prefix_last = (step_r == STEP_W'(LOG_N - 1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sec_r     <= '0;
      next_id_r <= '0;
      count_r   <= '0;
    end else begin
      if (cmd.decode && cmd.tick_adv) begin
        sec_r <= sec_inc;
      end
      if (cmd.insert) begin
        next_id_r <= nid_r;
        count_r   <= count_r + CNT_W'(1);
      end else if (cmd.remove) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      req_r   <= req_t'(in_req_type);
      delay_r <= in_delay_seconds[DLY_W-1:0];
      tag_r   <= in_tag;
      cid_r   <= in_cancel_id;
    end
    if (cmd.decode) begin
      wake_r     <= sec_r + delay_eff;
      nid_r      <= nid_calc;
      kill_r     <= cmd.tick_adv ? '1 : match;
      step_r     <= '0;
      head_id_r  <= id_r[0];
      head_tag_r <= etag_r[0];
    end else if (cmd.prefix) begin
      kill_r <= kill_r | (kill_r << shamt);
      step_r <= step_r + STEP_W'(1);
    end
    if (cmd.load_out) begin
      status_r <= cmd.status;
      aid_r    <= cmd.assign_id ? nid_ext[OUT_ID_W-1:0] : '0;
      fired_r  <= cmd.fired;
      fid_r    <= cmd.fired ? head_ext[OUT_ID_W-1:0] : '0;
      ftag_r   <= cmd.fired ? head_tag_r : '0;
    end
  end

  assign out_status      = status_r;
  assign out_assigned_id = aid_r;
  assign out_fired       = fired_r;
  assign out_fired_id    = fid_r;
  assign out_fired_tag   = ftag_r;

endmodule

`default_nettype wire

[rtl/sorted_timer_queue_unit.sv]
// Sorted timer queue: holds up to NUM_TIMERS pending timers in expiry order in a row of
// shifting slots, together with a seconds counter and an id counter. Each input word is a
// schedule, a cancel or a one-second tick, and each gives exactly one result word. The block
// takes one word at a time and closes its input until that word's result is loaded into the
// output register. Each word is latched and decoded; a schedule that is taken then inserts,
// a tick that fires removes the head, and a cancel that finds its id runs the parallel-prefix
// pass that marks the matching slot and the slots behind it, then removes that timer; all
// other words go straight to the result. A finished result waits in the output register, so
// a stalled output holds back only the next result, not the next input.
`default_nettype none

module sorted_timer_queue_unit import stq_pkg::*; #(
  parameter int NUM_TIMERS = 16,
  parameter int ID_BITS    = 16,
  parameter int DELAY_BITS = 20
) (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    in_valid,
  output logic                   in_stall,
  input  wire  [REQ_W-1:0]       in_req_type,
  input  wire  [DELAY_IN_W-1:0]  in_delay_seconds,
  input  wire  [TAG_W-1:0]       in_tag,
  input  wire  [CID_W-1:0]       in_cancel_id,
  output logic                   out_valid,
  input  wire                    out_stall,
  output logic [STATUS_W-1:0]    out_status,
  output logic [OUT_ID_W-1:0]    out_assigned_id,
  output logic                   out_fired,
  output logic [OUT_ID_W-1:0]    out_fired_id,
  output logic [TAG_W-1:0]       out_fired_tag
);

  ctl_cmd_t cmd;
  dp_stat_t stat;

  stq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  stq_dpath #(
    .NUM_TIMERS (NUM_TIMERS),
    .ID_BITS    (ID_BITS),
    .DELAY_BITS (DELAY_BITS)
  ) u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_req_type      (in_req_type),
    .in_delay_seconds (in_delay_seconds),
    .in_tag           (in_tag),
    .in_cancel_id     (in_cancel_id),
    .cmd              (cmd),
    .stat             (stat),
    .out_status       (out_status),
    .out_assigned_id  (out_assigned_id),
    .out_fired        (out_fired),
    .out_fired_id     (out_fired_id),
    .out_fired_tag    (out_fired_tag)
  );

endmodule

`default_nettype wire

[rtl/stq_checker.sv]
`default_nettype none
`include "sorted_timer_queue_unit_defines.svh"

module stq_checker import stq_pkg::*; (
  input wire                   clk,
  input wire                   rst_n,
  input wire                   in_valid,
  input wire                   in_stall,
  input wire                   out_valid,
  input wire                   out_stall,
  input wire [STATUS_W-1:0]    out_status,
  input wire [OUT_ID_W-1:0]    out_assigned_id,
  input wire                   out_fired,
  input wire [OUT_ID_W-1:0]    out_fired_id,
  input wire [TAG_W-1:0]       out_fired_tag
);

  wire [STATUS_W+2*OUT_ID_W+TAG_W:0] out_word =
    {out_status, out_assigned_id, out_fired, out_fired_id, out_fired_tag};
  wire [OUT_ID_W+TAG_W-1:0] fire_fields = {out_fired_id, out_fired_tag};

  // A word is worked on alone, so an accepted word closes the input for the next cycle.
  `STQ_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "input open after accept")

  `STQ_ASSERT_NEXT(a_hold, out_valid && out_stall, out_valid && $stable(out_word), "word changed")

  `STQ_ASSERT_NOW(a_fire_on_tick, out_valid && out_fired, out_status == STS_TICK, "fire off tick")

  `STQ_ASSERT_NOW(a_no_fire_zero, out_valid && !out_fired, fire_fields == '0, "stray fire fields")

endmodule

bind sorted_timer_queue_unit stq_checker u_stq_checker (.*);

`default_nettype wire
